FILE: rtl/knp_pkg.sv
// Package for the k-nearest-points unit: widths, key and cell types, FSM codes
// and the key ordering function. Used by the top level and knp_cell. No dependencies.
package knp_pkg;

  localparam int CAPACITY   = 1024;
  localparam int COORD_BITS = 16;
  localparam int MAX_EMIT   = 64;
  localparam int DIST_W     = 32;
  localparam int K_W        = 7;

  localparam int IDX_W  = $clog2(CAPACITY);
  localparam int CNT_W  = IDX_W + 1;
  localparam int EMIT_W = $clog2(MAX_EMIT + 1);
  localparam int SQ_W   = 2 * COORD_BITS;
  localparam int SUM_W  = ((SQ_W > DIST_W) ? SQ_W : DIST_W) + 1;
  localparam int PT_W   = 2 * COORD_BITS;

  // heap key: distance first, then arrival index
  typedef struct packed {
    logic [DIST_W-1:0] dist_sq;
    logic [IDX_W-1:0]  idx;
  } key_t;

  typedef struct packed {
    logic valid;
    key_t key;
  } cell_t;

  // per-cycle command broadcast to every cell of the chain
  typedef struct packed {
    logic insert;
    logic pop;
    logic clear;
  } chain_ctrl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_INSERT,
    ST_EMIT
  } state_t;

  function automatic logic key_less(key_t a, key_t b);
    key_less = (a.dist_sq < b.dist_sq) || ((a.dist_sq == b.dist_sq) && (a.idx < b.idx));
  endfunction

endpackage

FILE: rtl/k_nearest_points_heap_unit.sv
// Top level of the k-nearest-points unit: distance pipeline, sorted cell chain,
// point store and control FSM. Depends on knp_pkg, knp_ram and knp_cell.
//
// Usage:
//   Input requests (in_x, in_y, in_last_point) are taken on a rising edge with
//   start high and busy low. Each point passes through accept, squaring, and
//   an insert into a row of MAX_EMIT cells that keeps the smallest keys
//   (distance, then arrival index) in ascending order. A new point is not
//   taken until the insert of the last one is done, as busy stays high.
//   Up to CAPACITY points are stored per set; later ones are dropped and
//   out_overflowed is raised on the results of that set.
//   On a point with in_last_point set, min(k_count, count) results follow,
//   k_count saturating at MAX_EMIT. The head cell is popped once per cycle
//   and its point read from the registered store, and the results follow
//   one per cycle. busy drops once the final pop, which clears the set, is
//   issued. Each result is shown for one cycle with out_strobe; the receiver
//   cannot stall. cfg_we writes k_count; the user must write it only while
//   idle, which the block does not enforce. Reset empties the chain, clears
//   the counters and sets k_count to 1; the point store needs no clearing.
module k_nearest_points_heap_unit (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  output logic                                  busy,
  input  logic signed [knp_pkg::COORD_BITS-1:0] in_x,
  input  logic signed [knp_pkg::COORD_BITS-1:0] in_y,
  input  logic                                  in_last_point,
  output logic                                  out_strobe,
  output logic [knp_pkg::IDX_W-1:0]             out_point_index,
  output logic signed [knp_pkg::COORD_BITS-1:0] out_x_out,
  output logic signed [knp_pkg::COORD_BITS-1:0] out_y_out,
  output logic                                  out_last_result,
  output logic                                  out_overflowed,
  input  logic                                  cfg_we,
  input  logic [knp_pkg::K_W-1:0]               cfg_wdata
);

  localparam int C = knp_pkg::COORD_BITS;
  localparam int N = knp_pkg::MAX_EMIT;

  knp_pkg::state_t state_r, state_nxt;

  logic [knp_pkg::K_W-1:0]    k_count_r;
  logic [knp_pkg::CNT_W-1:0]  arrival_r, arrival_nxt;
  logic                       ovf_r, ovf_nxt;
  logic [knp_pkg::EMIT_W-1:0] emit_left_r, emit_left_nxt;

  // per-point pipeline payload
  logic [C-1:0]                x_r, y_r;
  logic [knp_pkg::IDX_W-1:0]   idx_r;
  logic                        last_r, drop_r;
  logic [knp_pkg::SQ_W-1:0]    sqx_r, sqy_r;

  // result stage
  logic                        o_pend_r, o_pend_nxt;
  logic [knp_pkg::IDX_W-1:0]   o_idx_r;
  logic                        o_last_r, o_ovf_r;

  logic                        accept, full;
  logic [C-1:0]                ax, ay;
  logic [knp_pkg::SUM_W-1:0]   sum;
  logic [knp_pkg::DIST_W-1:0]  dist_sat;
  logic [knp_pkg::K_W-1:0]     k_sat;
  logic [knp_pkg::EMIT_W-1:0]  n_emit;
  knp_pkg::chain_ctrl_t        ctrl;
  knp_pkg::key_t               new_key;
  knp_pkg::cell_t              cells [N];
  logic                        less  [N];
  logic [knp_pkg::PT_W-1:0]    rdata;

  assign busy   = (state_r != knp_pkg::ST_IDLE);
  assign accept = start && !busy;
  assign full   = (arrival_r == knp_pkg::CNT_W'(knp_pkg::CAPACITY));

  // point store, written at accept in arrival order
  knp_ram #(
    .WIDTH(knp_pkg::PT_W),
    .DEPTH(knp_pkg::CAPACITY)
  ) u_store (
    .clk  (clk),
    .we   (accept && !full),
    .waddr(arrival_r[knp_pkg::IDX_W-1:0]),
    .wdata({in_x, in_y}),
    .raddr(cells[0].key.idx),
    .rdata(rdata)
  );

  // magnitudes; the most negative value maps to 2^(C-1) as unsigned
  assign ax = x_r[C-1] ? (~x_r + C'(1)) : x_r;
  assign ay = y_r[C-1] ? (~y_r + C'(1)) : y_r;

  // squared distance, saturated to the key width
  assign sum      = knp_pkg::SUM_W'(sqx_r) + knp_pkg::SUM_W'(sqy_r);
  assign dist_sat = (|sum[knp_pkg::SUM_W-1:knp_pkg::DIST_W]) ? '1 :
                    sum[knp_pkg::DIST_W-1:0];

  assign new_key.dist_sq = dist_sat;
  assign new_key.idx     = idx_r;

  // results to emit: min(saturated k, stored count)
  assign k_sat  = (k_count_r > knp_pkg::K_W'(N)) ? knp_pkg::K_W'(N) : k_count_r;
  assign n_emit = (knp_pkg::CNT_W'(k_sat) < arrival_r) ?
                  knp_pkg::EMIT_W'(k_sat) : arrival_r[knp_pkg::EMIT_W-1:0];

  // sorted chain of cells
  for (genvar i = 0; i < N; i++) begin : g_cell
    knp_pkg::cell_t left_c, right_c;
    logic           left_l;
    if (i == 0) begin : g_head
      assign left_c = '0;
      assign left_l = 1'b0;
    end else begin : g_mid
      assign left_c = cells[i-1];
      assign left_l = less[i-1];
    end
    if (i == N - 1) begin : g_tail
      assign right_c = '0;
    end else begin : g_body
      assign right_c = cells[i+1];
    end
    knp_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctrl     (ctrl),
      .new_key  (new_key),
      .left_less(left_l),
      .left     (left_c),
      .right    (right_c),
      .held     (cells[i]),
      .less     (less[i])
    );
  end

  // next state and chain control
  always_comb begin
    state_nxt     = state_r;
    arrival_nxt   = arrival_r;
    ovf_nxt       = ovf_r;
    emit_left_nxt = emit_left_r;
    o_pend_nxt    = 1'b0;
    ctrl          = '0;
    unique case (state_r)
      knp_pkg::ST_IDLE: begin
        if (accept) begin
          state_nxt = knp_pkg::ST_SQUARE;
          if (full) begin
            ovf_nxt = 1'b1;
          end else begin
            arrival_nxt = arrival_r + knp_pkg::CNT_W'(1);
          end
        end
      end
      knp_pkg::ST_SQUARE: begin
        state_nxt = knp_pkg::ST_INSERT;
      end
      knp_pkg::ST_INSERT: begin
        ctrl.insert = !drop_r;
        state_nxt   = knp_pkg::ST_IDLE;
        if (last_r) begin
          if (n_emit == '0) begin
            ctrl.clear  = 1'b1;
            arrival_nxt = '0;
            ovf_nxt     = 1'b0;
          end else begin
            emit_left_nxt = n_emit;
            state_nxt     = knp_pkg::ST_EMIT;
          end
        end
      end
      knp_pkg::ST_EMIT: begin
        ctrl.pop      = 1'b1;
        o_pend_nxt    = 1'b1;
        emit_left_nxt = emit_left_r - knp_pkg::EMIT_W'(1);
        if (emit_left_r == knp_pkg::EMIT_W'(1)) begin
          ctrl.clear  = 1'b1;
          arrival_nxt = '0;
          ovf_nxt     = 1'b0;
          state_nxt   = knp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = knp_pkg::ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= knp_pkg::ST_IDLE;
      arrival_r   <= '0;
      ovf_r       <= 1'b0;
      emit_left_r <= '0;
      o_pend_r    <= 1'b0;
      k_count_r   <= knp_pkg::K_W'(1);
    end else begin
      state_r     <= state_nxt;
      arrival_r   <= arrival_nxt;
      ovf_r       <= ovf_nxt;
      emit_left_r <= emit_left_nxt;
      o_pend_r    <= o_pend_nxt;
      if (cfg_we) begin
        k_count_r <= cfg_wdata;
      end
    end
  end

  // point pipeline payload
  always_ff @(posedge clk) begin
    if (accept) begin
      x_r    <= in_x;
      y_r    <= in_y;
      idx_r  <= arrival_r[knp_pkg::IDX_W-1:0];
      last_r <= in_last_point;
      drop_r <= full;
    end
    if (state_r == knp_pkg::ST_SQUARE) begin
      sqx_r <= knp_pkg::SQ_W'(ax) * knp_pkg::SQ_W'(ax);
      sqy_r <= knp_pkg::SQ_W'(ay) * knp_pkg::SQ_W'(ay);
    end
  end

  // result payload, aligned with the registered store read
  always_ff @(posedge clk) begin
    if (state_r == knp_pkg::ST_EMIT) begin
      o_idx_r  <= cells[0].key.idx;
      o_last_r <= (emit_left_r == knp_pkg::EMIT_W'(1));
      o_ovf_r  <= ovf_r;
    end
  end

  assign out_strobe      = o_pend_r;
  assign out_point_index = o_idx_r;
  assign out_x_out       = rdata[knp_pkg::PT_W-1:C];
  assign out_y_out       = rdata[C-1:0];
  assign out_last_result = o_last_r;
  assign out_overflowed  = o_ovf_r;

  // a pop always finds a key at the head
  a_pop_has_key: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == knp_pkg::ST_EMIT) |-> cells[0].valid)
    else $error("pop from empty chain");

  // the first two cells stay packed and in ascending order
  a_head_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    cells[1].valid |-> (cells[0].valid && knp_pkg::key_less(cells[0].key, cells[1].key)))
    else $error("chain head out of order");

  // the final result of a run leaves the emit state behind
  a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_last_result) |-> (state_r != knp_pkg::ST_EMIT))
    else $error("emission continues after final result");

  // results only come from pops
  a_strobe_from_pop: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(state_r == knp_pkg::ST_EMIT))
    else $error("result without pop");

  // an accepted request always makes the unit busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == knp_pkg::ST_SQUARE))
    else $error("accepted request not taken up");

endmodule

FILE: rtl/knp_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module knp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/knp_cell.sv
// One cell of the sorted insertion chain: holds one key and its valid bit.
// Depends on knp_pkg.
module knp_cell (
  input  logic                 clk,
  input  logic                 rst_n,
  input  knp_pkg::chain_ctrl_t ctrl,
  input  knp_pkg::key_t        new_key,
  input  logic                 left_less,
  input  knp_pkg::cell_t       left,
  input  knp_pkg::cell_t       right,
  output knp_pkg::cell_t       held,
  output logic                 less
);

  knp_pkg::cell_t cell_r, cell_nxt;

  // new key belongs at or before this cell; an empty cell counts as infinity
  assign less = !cell_r.valid || knp_pkg::key_less(new_key, cell_r.key);
  assign held = cell_r;

  always_comb begin
    cell_nxt = cell_r;
    priority if (ctrl.clear) begin
      cell_nxt.valid = 1'b0;
    end else if (ctrl.pop) begin
      cell_nxt = right;
    end else if (ctrl.insert && less) begin
      if (left_less) begin
        // left neighbor is displaced too: shift its key in
        cell_nxt = left;
      end else begin
        cell_nxt.valid = 1'b1;
        cell_nxt.key   = new_key;
      end
    end
  end

  // valid bit is reset, key payload is not
  always_ff @(posedge clk) begin
    cell_r.key <= cell_nxt.key;
    if (!rst_n) begin
      cell_r.valid <= 1'b0;
    end else begin
      cell_r.valid <= cell_nxt.valid;
    end
  end

endmodule
